FILE: src/sct_pkg.sv
// Shared package for the command line tokenizer.
// Token and bundle types, token and pending codes, byte constants, line length and queue depth.
// No dependencies.
`default_nettype none

package sct_pkg;

    localparam int LINE_BYTES_DEF = 256;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [2:0] TOK_EOF      = 3'd0;
    localparam logic [2:0] TOK_END      = 3'd1;
    localparam logic [2:0] TOK_COMMENT  = 3'd2;
    localparam logic [2:0] TOK_COMMAND  = 3'd3;
    localparam logic [2:0] TOK_FLAG     = 3'd4;
    localparam logic [2:0] TOK_PIPE     = 3'd5;
    localparam logic [2:0] TOK_REDIR_IN = 3'd6;
    localparam logic [2:0] TOK_REDIR_OUT = 3'd7;

    localparam logic [1:0] PEND_NONE    = 2'd0;
    localparam logic [1:0] PEND_IN      = 2'd1;
    localparam logic [1:0] PEND_OUT     = 2'd2;
    localparam logic [1:0] PEND_COMMENT = 2'd3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_NL    = 8'h0A;

    typedef struct packed {
        logic [2:0] token_type;
        logic [7:0] value_start;
        logic [8:0] value_length;
        logic       too_long;
        logic       last;
    } t_token;

    // Up to two tokens produced by one input byte.
    typedef struct packed {
        t_token tok0;
        t_token tok1;
        logic   two;
    } t_bundle;

endpackage

`default_nettype wire

FILE: src/shell_command_tokenizer.sv
// Command line tokenizer top level: front end, bundle queue, output stage.
// Depends on sct_pkg, sct_front, sct_queue, sct_back.
//
// Takes one byte of a command line per clock while the queue has room and
// emits typed tokens with the offset and length of their value. Each byte
// yields zero, one or two tokens; the output register delivers one token per
// clock while the receiver is ready, so a stream of one byte per clock keeps
// going at full rate except where a byte yields two tokens (a word closed by
// the line end, a dangling redirect or comment); the four-bundle queue absorbs
// the extra output. From byte to output, a token passes the queue register and
// then the output register.
`default_nettype none

module shell_command_tokenizer #(
    parameter int LINE_BYTES = sct_pkg::LINE_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_character,
    input  wire logic       i_line_end,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [2:0]      o_token_type,
    output logic [7:0]      o_value_start,
    output logic [8:0]      o_value_length,
    output logic            o_too_long,
    output logic            o_last
);
    import sct_pkg::*;

    logic    push;
    logic    full;
    logic    pop;
    logic    empty;
    t_bundle push_data;
    t_bundle head;
    t_token  tok;

    sct_front #(
        .LINE_BYTES (LINE_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_character (i_character),
        .i_line_end  (i_line_end),
        .o_ready     (o_in_ready),
        .o_push      (push),
        .o_bundle    (push_data),
        .i_full      (full)
    );

    sct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty)
    );

    sct_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .o_tok   (tok),
        .i_ready (i_out_ready)
    );

    assign o_token_type   = tok.token_type;
    assign o_value_start  = tok.value_start;
    assign o_value_length = tok.value_length;
    assign o_too_long     = tok.too_long;
    assign o_last         = tok.last;

endmodule

`default_nettype wire

FILE: src/sct_front.sv
// Tokenizer front end: takes bytes, tracks the current word and classifies it.
// Pushes a bundle of up to two tokens into the queue for each byte that closes a token or the line.
// Depends on sct_pkg.
`default_nettype none

module sct_front #(
    parameter int LINE_BYTES = sct_pkg::LINE_BYTES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [7:0]       i_character,
    input  wire logic             i_line_end,
    output logic                  o_ready,
    output logic                  o_push,
    output sct_pkg::t_bundle      o_bundle,
    input  wire logic             i_full
);
    import sct_pkg::*;

    localparam int SW_S = $clog2(LINE_BYTES);
    localparam int PW   = SW_S + 1;
    localparam int SW   = (PW > 9) ? PW : 9;

    logic [PW-1:0]   r_line_pos,   n_line_pos;
    logic [SW_S-1:0] r_word_start, n_word_start;
    logic [PW-1:0]   r_word_len,   n_word_len;
    logic            r_inside,     n_inside;
    logic            r_quoted,     n_quoted;
    logic [7:0]      r_first,      n_first;
    logic [7:0]      r_second,     n_second;
    logic [7:0]      r_prev,       n_prev;
    logic            r_cmd_seen,   n_cmd_seen;
    logic [1:0]      r_pending,    n_pending;
    logic            r_ovf,        n_ovf;

    logic            accept;
    logic            pos_sat;
    logic [SW_S-1:0] pos;
    logic            space_fin;
    logic            do_fin;
    logic            strip;
    logic [SW-1:0]   vstart;
    logic [SW-1:0]   vlen;
    logic [7:0]      c0;
    logic            ovf_now;
    logic            fin_emit;
    logic            pend_emit;
    t_token          fin_tok;
    t_token          pend_tok;
    t_token          eof_tok;
    logic [2:0]      pend_type;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        n_line_pos   = r_line_pos;
        n_word_start = r_word_start;
        n_word_len   = r_word_len;
        n_inside     = r_inside;
        n_quoted     = r_quoted;
        n_first      = r_first;
        n_second     = r_second;
        n_prev       = r_prev;
        n_cmd_seen   = r_cmd_seen;
        n_pending    = r_pending;
        n_ovf        = r_ovf;
        space_fin    = 1'b0;
        fin_emit     = 1'b0;
        fin_tok      = '0;
        pend_emit    = 1'b0;
        pend_tok     = '0;
        pend_type    = TOK_COMMENT;
        eof_tok      = '0;

        pos_sat = (r_line_pos >= PW'(LINE_BYTES));
        if (pos_sat) begin
            n_ovf = 1'b1;
            pos   = SW_S'(LINE_BYTES - 1);
        end else begin
            pos        = r_line_pos[SW_S-1:0];
            n_line_pos = r_line_pos + PW'(1);
        end
        ovf_now = n_ovf;

        // byte update
        if (!r_inside) begin
            if (i_character != CH_SPACE) begin
                n_inside     = 1'b1;
                n_word_start = pos;
                n_word_len   = PW'(1);
                n_quoted     = (i_character == CH_QUOTE);
                n_first      = i_character;
                n_second     = 8'h00;
                n_prev       = i_character;
            end
        end else if (i_character == CH_SPACE &&
                     (!r_quoted || (r_prev == CH_QUOTE && r_word_len >= PW'(2)))) begin
            space_fin = 1'b1;
        end else begin
            if (r_word_len == PW'(1)) begin
                n_second = i_character;
            end
            n_prev = i_character;
            if (r_word_len < PW'(LINE_BYTES)) begin
                n_word_len = r_word_len + PW'(1);
            end
        end

        // word close
        do_fin = space_fin || (i_line_end && n_inside);
        strip  = (n_first == CH_QUOTE) && (n_prev == CH_QUOTE);
        vstart = SW'(n_word_start) + SW'(strip);
        if (strip) begin
            vlen = (n_word_len >= PW'(2)) ? (SW'(n_word_len) - SW'(2)) : '0;
            c0   = n_second;
        end else begin
            vlen = SW'(n_word_len);
            c0   = n_first;
        end

        if (do_fin) begin
            n_inside = 1'b0;
            fin_tok.too_long = ovf_now;
            if (r_pending != PEND_NONE) begin
                fin_emit = 1'b1;
                fin_tok.token_type = (r_pending == PEND_IN)  ? TOK_REDIR_IN :
                                     (r_pending == PEND_OUT) ? TOK_REDIR_OUT : TOK_COMMENT;
                fin_tok.value_start  = vstart[7:0];
                fin_tok.value_length = vlen[8:0];
                n_pending = PEND_NONE;
            end else if (vlen == SW'(1) && c0 == CH_LT) begin
                n_pending = PEND_IN;
            end else if (vlen == SW'(1) && c0 == CH_GT) begin
                n_pending = PEND_OUT;
            end else if (vlen == SW'(1) && c0 == CH_PIPE) begin
                fin_emit = 1'b1;
                fin_tok.token_type = TOK_PIPE;
                n_cmd_seen = 1'b0;
            end else if (vlen == SW'(1) && c0 == CH_HASH) begin
                n_pending = PEND_COMMENT;
            end else if (vlen >= SW'(1) && c0 == CH_HASH) begin
                fin_emit = 1'b1;
                fin_tok.token_type   = TOK_COMMENT;
                fin_tok.value_start  = 8'(vstart + SW'(1));
                fin_tok.value_length = 9'(vlen - SW'(1));
            end else if (vlen == SW'(1) && c0 == CH_SEMI) begin
                fin_emit = 1'b1;
                fin_tok.token_type = TOK_END;
                n_cmd_seen = 1'b0;
            end else if (vlen >= SW'(1) && c0 == CH_NL) begin
                fin_emit = 1'b1;
                fin_tok.token_type = TOK_END;
            end else begin
                fin_emit = 1'b1;
                fin_tok.token_type   = r_cmd_seen ? TOK_FLAG : TOK_COMMAND;
                fin_tok.value_start  = vstart[7:0];
                fin_tok.value_length = vlen[8:0];
                n_cmd_seen = 1'b1;
            end
        end

        // line close: dangling redirect or comment, then eof
        if (i_line_end) begin
            if (n_pending == PEND_IN) begin
                pend_type = TOK_REDIR_IN;
            end else if (n_pending == PEND_OUT) begin
                pend_type = TOK_REDIR_OUT;
            end
            pend_emit           = (n_pending != PEND_NONE);
            pend_tok.token_type = pend_type;
            pend_tok.too_long   = ovf_now;
            eof_tok.token_type  = TOK_EOF;
            eof_tok.too_long    = ovf_now;
            eof_tok.last        = 1'b1;

            n_line_pos   = '0;
            n_word_start = '0;
            n_word_len   = '0;
            n_inside     = 1'b0;
            n_quoted     = 1'b0;
            n_first      = 8'h00;
            n_second     = 8'h00;
            n_prev       = 8'h00;
            n_cmd_seen   = 1'b0;
            n_pending    = PEND_NONE;
            n_ovf        = 1'b0;
        end
    end

    always_comb begin
        o_bundle = '0;
        if (fin_emit) begin
            o_bundle.tok0 = fin_tok;
            o_bundle.tok1 = pend_emit ? pend_tok : eof_tok;
            o_bundle.two  = i_line_end;
        end else if (pend_emit) begin
            o_bundle.tok0 = pend_tok;
            o_bundle.tok1 = eof_tok;
            o_bundle.two  = 1'b1;
        end else begin
            o_bundle.tok0 = eof_tok;
        end
    end

    assign o_push = accept && (fin_emit || i_line_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_pos   <= '0;
            r_word_start <= '0;
            r_word_len   <= '0;
            r_inside     <= 1'b0;
            r_quoted     <= 1'b0;
            r_first      <= 8'h00;
            r_second     <= 8'h00;
            r_prev       <= 8'h00;
            r_cmd_seen   <= 1'b0;
            r_pending    <= PEND_NONE;
            r_ovf        <= 1'b0;
        end else if (accept) begin
            r_line_pos   <= n_line_pos;
            r_word_start <= n_word_start;
            r_word_len   <= n_word_len;
            r_inside     <= n_inside;
            r_quoted     <= n_quoted;
            r_first      <= n_first;
            r_second     <= n_second;
            r_prev       <= n_prev;
            r_cmd_seen   <= n_cmd_seen;
            r_pending    <= n_pending;
            r_ovf        <= n_ovf;
        end
    end

endmodule

`default_nettype wire

FILE: src/sct_queue.sv
// Short bundle queue between tokenizer front end and output stage.
// Register based, head visible combinationally.
// Depends on sct_pkg.
`default_nettype none

module sct_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire sct_pkg::t_bundle  i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output sct_pkg::t_bundle       o_head,
    output logic                   o_empty
);
    import sct_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_bundle       r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_count;

    assign o_full  = (r_count == (AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (AW+1)'(1);
                2'b01:   r_count <= r_count - (AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/sct_back.sv
// Output stage: serialises queued bundles into single tokens.
// Holds the output register of the result channel.
// Depends on sct_pkg.
`default_nettype none

module sct_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sct_pkg::t_bundle  i_head,
    input  wire logic              i_empty,
    output logic                   o_pop,
    output logic                   o_valid,
    output sct_pkg::t_token        o_tok,
    input  wire logic              i_ready
);
    import sct_pkg::*;

    logic   r_valid;
    logic   r_half;
    t_token r_tok;
    logic   load;

    assign load    = (!r_valid || i_ready) && !i_empty;
    assign o_pop   = load && (r_half || !i_head.two);
    assign o_valid = r_valid;
    assign o_tok   = r_tok;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tok <= r_half ? i_head.tok1 : i_head.tok0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_half  <= !o_pop;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/tb_shell_command_tokenizer.sv
// Self-checking testbench for shell_command_tokenizer.
// Directed table then random command lines, scored against a local tokenizer model.
// Depends on sct_pkg and the shell_command_tokenizer RTL.
`default_nettype none

module tb_shell_command_tokenizer;
    import sct_pkg::*;

    localparam int LINE_BYTES  = LINE_BYTES_DEF;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TOTAL_ITEMS = 2020;

    typedef struct {
        logic [7:0] ch;
        bit         le;
        int         n_typed;
        t_token     t0;
        t_token     t1;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_character;
    logic       i_line_end;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [2:0] o_token_type;
    logic [7:0] o_value_start;
    logic [8:0] o_value_length;
    logic       o_too_long;
    logic       o_last;

    shell_command_tokenizer u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_character    (i_character),
        .i_line_end     (i_line_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_token_type   (o_token_type),
        .o_value_start  (o_value_start),
        .o_value_length (o_value_length),
        .o_too_long     (o_too_long),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // tokenizer state
    int         line_pos;
    int         word_at;
    int         word_len;
    bit         in_word;
    bit         word_quoted;
    logic [7:0] first_ch;
    logic [7:0] second_ch;
    logic [7:0] prev_ch;
    bit         cmd_seen;
    logic [1:0] pending;
    bit         overflow;

    t_token     tokens_due[$];
    t_row       dir_rows[$];
    logic [7:0] line_bytes[$];
    int         items_taken;
    int         tokens_seen;
    int         mismatches;
    int         burst_left;
    int         idle_cycles;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("MISMATCH token %0d: %s", tokens_seen, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    function automatic void clear_line();
        line_pos    = 0;
        word_at     = 0;
        word_len    = 0;
        in_word     = 1'b0;
        word_quoted = 1'b0;
        first_ch    = '0;
        second_ch   = '0;
        prev_ch     = '0;
        cmd_seen    = 1'b0;
        pending     = PEND_NONE;
        overflow    = 1'b0;
    endfunction

    function automatic void push_token(logic [2:0] kind, int start, int len, bit last);
        t_token t;
        t.token_type   = kind;
        t.value_start  = start[7:0];
        t.value_length = len[8:0];
        t.too_long     = overflow;
        t.last         = last;
        tokens_due.push_back(t);
    endfunction

    function automatic logic [2:0] pending_type();
        case (pending)
            PEND_IN:  return TOK_REDIR_IN;
            PEND_OUT: return TOK_REDIR_OUT;
            default:  return TOK_COMMENT;
        endcase
    endfunction

    function automatic void close_word();
        bit         strip;
        int         vstart;
        int         vlen;
        logic [7:0] c0;
        strip  = (first_ch == CH_QUOTE) && (prev_ch == CH_QUOTE);
        vstart = word_at + (strip ? 1 : 0);
        vlen   = strip ? (word_len >= 2 ? word_len - 2 : 0) : word_len;
        c0     = strip ? second_ch : first_ch;
        in_word = 1'b0;
        if (pending != PEND_NONE) begin
            push_token(pending_type(), vstart, vlen, 1'b0);
            pending = PEND_NONE;
        end else if (vlen == 1 && c0 == CH_LT) begin
            pending = PEND_IN;
        end else if (vlen == 1 && c0 == CH_GT) begin
            pending = PEND_OUT;
        end else if (vlen == 1 && c0 == CH_PIPE) begin
            cmd_seen = 1'b0;
            push_token(TOK_PIPE, 0, 0, 1'b0);
        end else if (vlen == 1 && c0 == CH_HASH) begin
            pending = PEND_COMMENT;
        end else if (vlen >= 1 && c0 == CH_HASH) begin
            push_token(TOK_COMMENT, vstart + 1, vlen - 1, 1'b0);
        end else if (vlen == 1 && c0 == CH_SEMI) begin
            cmd_seen = 1'b0;
            push_token(TOK_END, 0, 0, 1'b0);
        end else if (vlen >= 1 && c0 == CH_NL) begin
            push_token(TOK_END, 0, 0, 1'b0);
        end else if (!cmd_seen) begin
            cmd_seen = 1'b1;
            push_token(TOK_COMMAND, vstart, vlen, 1'b0);
        end else begin
            push_token(TOK_FLAG, vstart, vlen, 1'b0);
        end
    endfunction

    function automatic void tokenize_byte(logic [7:0] ch, bit le);
        int pos;
        if (line_pos >= LINE_BYTES) begin
            overflow = 1'b1;
            pos      = LINE_BYTES - 1;
        end else begin
            pos = line_pos;
            line_pos++;
        end
        if (!in_word) begin
            if (ch != CH_SPACE) begin
                in_word     = 1'b1;
                word_at     = pos;
                word_len    = 1;
                word_quoted = (ch == CH_QUOTE);
                first_ch    = ch;
                second_ch   = '0;
                prev_ch     = ch;
            end
        end else if (ch == CH_SPACE && (!word_quoted || (prev_ch == CH_QUOTE && word_len >= 2))) begin
            close_word();
        end else begin
            if (word_len == 1)
                second_ch = ch;
            prev_ch = ch;
            if (word_len < LINE_BYTES)
                word_len++;
        end
        if (le) begin
            if (in_word)
                close_word();
            if (pending != PEND_NONE) begin
                push_token(pending_type(), 0, 0, 1'b0);
                pending = PEND_NONE;
            end
            push_token(TOK_EOF, 0, 0, 1'b1);
            clear_line();
        end
    endfunction

    function automatic t_token tok(logic [2:0] kind, int start, int len, bit last);
        t_token t;
        t.token_type   = kind;
        t.value_start  = start[7:0];
        t.value_length = len[8:0];
        t.too_long     = 1'b0;
        t.last         = last;
        return t;
    endfunction

    function automatic void add_row(logic [7:0] ch, bit le, int n_typed, t_token t0, t_token t1);
        t_row r;
        r.ch      = ch;
        r.le      = le;
        r.n_typed = n_typed;
        r.t0      = t0;
        r.t1      = t1;
        dir_rows.push_back(r);
    endfunction

    function automatic logic [7:0] nonspace_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (b == CH_SPACE);
        return b;
    endfunction

    function automatic logic [7:0] text_byte();
        if ($urandom_range(0, 9) == 0)
            return nonspace_byte();
        return 8'(8'h61 + $urandom_range(0, 25));
    endfunction

    function automatic void add_word();
        case ($urandom_range(0, 15))
            0, 1, 2, 3: repeat ($urandom_range(1, 8)) line_bytes.push_back(text_byte());
            4: begin
                line_bytes.push_back(8'h2D);
                repeat ($urandom_range(1, 3))
                    line_bytes.push_back(8'(8'h61 + $urandom_range(0, 25)));
            end
            5, 6: begin
                line_bytes.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 6))
                    line_bytes.push_back($urandom_range(0, 3) == 0 ? CH_SPACE : text_byte());
                line_bytes.push_back(CH_QUOTE);
            end
            7:  line_bytes.push_back(CH_LT);
            8:  line_bytes.push_back(CH_GT);
            9:  line_bytes.push_back(CH_PIPE);
            10: line_bytes.push_back(CH_SEMI);
            11: line_bytes.push_back(CH_HASH);
            12: begin
                line_bytes.push_back(CH_HASH);
                repeat ($urandom_range(1, 5)) line_bytes.push_back(text_byte());
            end
            13: begin
                line_bytes.push_back(CH_NL);
                repeat ($urandom_range(0, 2)) line_bytes.push_back(text_byte());
            end
            14: repeat ($urandom_range(1, 6)) line_bytes.push_back(nonspace_byte());
            default: begin
                // unbalanced quote
                line_bytes.push_back(CH_QUOTE);
                repeat ($urandom_range(1, 4)) line_bytes.push_back(text_byte());
            end
        endcase
    endfunction

    function automatic void build_line(int idx);
        int n;
        int target;
        line_bytes.delete();
        if (idx % 40 == 7) begin
            // past the line store: one giant word, or many words
            target = $urandom_range(260, 300);
            if ((idx / 40) % 2 == 0) begin
                repeat (target) line_bytes.push_back(text_byte());
            end else begin
                while (line_bytes.size() < target) begin
                    add_word();
                    line_bytes.push_back(CH_SPACE);
                end
            end
        end else if ($urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 24);
            repeat (n)
                line_bytes.push_back($urandom_range(0, 3) == 0 ? CH_SPACE : nonspace_byte());
        end else begin
            if ($urandom_range(0, 5) == 0)
                line_bytes.push_back(CH_SPACE);
            n = $urandom_range(1, 7);
            repeat (n) begin
                add_word();
                repeat ($urandom_range(1, 2)) line_bytes.push_back(CH_SPACE);
            end
            if ($urandom_range(0, 4) != 0)
                void'(line_bytes.pop_back());
        end
    endfunction

    task automatic send_byte(input logic [7:0] ch, input bit le, input int n_typed,
                             input t_token t0, input t_token t1);
        int due_prior;
        int added;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(1, 30);
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_character <= ch;
        i_line_end  <= le;
        do @(posedge i_clk); while (!o_in_ready);
        items_taken++;
        due_prior = tokens_due.size();
        tokenize_byte(ch, le);
        if (n_typed >= 0) begin
            added = tokens_due.size() - due_prior;
            repeat (added) void'(tokens_due.pop_back());
            if (n_typed >= 1)
                tokens_due.push_back(t0);
            if (n_typed >= 2)
                tokens_due.push_back(t1);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tokens_due.size() != 0);
    endtask

    always @(posedge i_clk) begin : score_token
        t_token want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (tokens_due.size() == 0) begin
                report_mismatch($sformatf("unexpected token type %0d", o_token_type));
            end else begin
                want = tokens_due.pop_front();
                check_field("token_type", int'(o_token_type), int'(want.token_type));
                check_field("value_start", int'(o_value_start), int'(want.value_start));
                check_field("value_length", int'(o_value_length), int'(want.value_length));
                check_field("too_long", int'(o_too_long), int'(want.too_long));
                check_field("last", int'(o_last), int'(want.last));
            end
            tokens_seen++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_shell_command_tokenizer NOT OK");
            $finish;
        end
    end

    // receiver: stall patterns, plus one long hold-off so the block backs up
    initial begin : sink
        int  mode;
        int  span;
        bit  held;
        held = 1'b0;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!held && items_taken >= 600) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (120) @(posedge i_clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 60);
            repeat (span) begin
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    2: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default: i_out_ready <= ~i_out_ready;
                endcase
                @(posedge i_clk);
            end
        end
    end

    initial begin : source
        t_token eof_tok;
        t_token none;
        int     n_lines;
        bit     paused;
        clear_line();
        items_taken = 0;
        tokens_seen = 0;
        mismatches  = 0;
        burst_left  = 0;
        idle_cycles = 0;
        paused      = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_character <= '0;
        i_line_end  <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        eof_tok = tok(TOK_EOF, 0, 0, 1'b1);
        none    = '0;
        add_row(8'h61, 1'b1, 2, tok(TOK_COMMAND, 0, 1, 1'b0), eof_tok);
        add_row(CH_LT, 1'b1, 2, tok(TOK_REDIR_IN, 0, 0, 1'b0), eof_tok);
        add_row(CH_GT, 1'b1, 2, tok(TOK_REDIR_OUT, 0, 0, 1'b0), eof_tok);
        add_row(CH_HASH, 1'b1, 2, tok(TOK_COMMENT, 0, 0, 1'b0), eof_tok);
        add_row(CH_PIPE, 1'b1, 2, tok(TOK_PIPE, 0, 0, 1'b0), eof_tok);
        add_row(CH_SEMI, 1'b1, 2, tok(TOK_END, 0, 0, 1'b0), eof_tok);
        add_row(CH_NL, 1'b1, 2, tok(TOK_END, 0, 0, 1'b0), eof_tok);
        add_row(CH_SPACE, 1'b1, 1, eof_tok, none);
        add_row(8'hFF, 1'b1, 2, tok(TOK_COMMAND, 0, 1, 1'b0), eof_tok);
        add_row(8'h01, 1'b1, 2, tok(TOK_COMMAND, 0, 1, 1'b0), eof_tok);
        add_row(CH_QUOTE, 1'b1, -1, none, none);
        // quoted word holding a space, then a comment word
        add_row(CH_QUOTE, 1'b0, -1, none, none);
        add_row(8'h61, 1'b0, -1, none, none);
        add_row(CH_SPACE, 1'b0, -1, none, none);
        add_row(8'h62, 1'b0, -1, none, none);
        add_row(CH_QUOTE, 1'b0, -1, none, none);
        add_row(CH_SPACE, 1'b0, -1, none, none);
        add_row(CH_HASH, 1'b0, -1, none, none);
        add_row(8'h78, 1'b1, -1, none, none);
        // redirect as first word, with its value
        add_row(CH_GT, 1'b0, -1, none, none);
        add_row(CH_SPACE, 1'b0, -1, none, none);
        add_row(8'h66, 1'b1, -1, none, none);

        foreach (dir_rows[k])
            send_byte(dir_rows[k].ch, dir_rows[k].le, dir_rows[k].n_typed,
                      dir_rows[k].t0, dir_rows[k].t1);
        drain();

        n_lines = 0;
        while (items_taken < TOTAL_ITEMS) begin
            build_line(n_lines);
            foreach (line_bytes[k])
                send_byte(line_bytes[k], k == line_bytes.size() - 1, -1, none, none);
            n_lines++;
            if (!paused && items_taken >= 1200) begin
                paused = 1'b1;
                drain();
            end
        end
        drain();
        repeat (20) @(posedge i_clk);

        if (mismatches == 0)
            $display("tb_shell_command_tokenizer OK");
        else
            $display("tb_shell_command_tokenizer NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

FILE: shell_command_tokenizer.f
src/sct_pkg.sv
src/sct_front.sv
src/sct_queue.sv
src/sct_back.sv
src/shell_command_tokenizer.sv
tb/sv/tb_shell_command_tokenizer.sv
